// ===== hdl/idll_pkg.sv =====
// ----------------------------------------------------------------------------
// idll_pkg
// shared types and codes for the indexed doubly linked list core
// ----------------------------------------------------------------------------
package idll_pkg;

  // width of a node id on the ports and in the link memories
  localparam int ID_W = 10;

  // request codes on the mode field
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_WR2
  } state_t;

  // one write to each link memory in the same cycle
  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] l_addr;
    logic            l_pres;
    logic [ID_W-1:0] l_link;
    logic [ID_W-1:0] r_addr;
    logic [ID_W-1:0] r_link;
  } mem_wr_t;

  // read request: left memory at a and b, right memory at a
  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] a_addr;
    logic [ID_W-1:0] b_addr;
  } mem_rdreq_t;

  // registered read data
  typedef struct packed {
    logic            a_pres;
    logic [ID_W-1:0] a_left;
    logic            b_pres;
    logic [ID_W-1:0] b_left;
    logic [ID_W-1:0] a_right;
  } mem_rd_t;

endpackage

// ===== hdl/indexed_doubly_linked_list_core.sv =====
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_core
// array-indexed doubly linked list of node ids with node 0 as head sentinel
// ----------------------------------------------------------------------------
// Every word goes through the accept cycle, which issues the reads, a read
// step that sees the registered read data and does the first pair of link
// writes, and a last step that does the second pair of writes and loads the
// output register; the core then returns to idle for the next word. The pace
// is set by the single write port of each link memory, since an insert or a
// remove touches two entries of each. After reset the core runs a clearing
// pass over the first min(NODES, 1024) entries of the link memories, with
// in_ready low. Result words wait in an output register; a full output
// register holds the core in its last step until the word is taken.
module indexed_doubly_linked_list_core #(
  parameter int NODES = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 mode,
  input  logic [idll_pkg::ID_W-1:0]  node_id,
  input  logic [idll_pkg::ID_W-1:0]  anchor_id,
  input  logic                       side,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [idll_pkg::ID_W-1:0]  neighbour_id,
  output logic                       status
);

  localparam int DEPTH = (NODES < (1 << idll_pkg::ID_W)) ? NODES : (1 << idll_pkg::ID_W);
  localparam logic [idll_pkg::ID_W-1:0] CLR_LAST = idll_pkg::ID_W'(DEPTH - 1);

  idll_pkg::state_t state, state_next;

  // clearing pass address
  logic [idll_pkg::ID_W-1:0] clr_cnt;

  // captured request word
  logic [1:0]                req_mode;
  logic [idll_pkg::ID_W-1:0] req_node;
  logic [idll_pkg::ID_W-1:0] req_anchor;
  logic                      req_side;

  idll_pkg::mem_wr_t    mem_wr;
  idll_pkg::mem_rdreq_t mem_rd_req;
  idll_pkg::mem_rd_t    mem_rd;

  // decode of the read data
  logic                      node_pres;
  logic                      anchor_pres;
  logic                      ok;
  logic [idll_pkg::ID_W-1:0] nb;
  logic [idll_pkg::ID_W-1:0] res_nb_now;
  idll_pkg::mem_wr_t         wr1;
  idll_pkg::mem_wr_t         wr2_now;

  // held across the second write cycle
  idll_pkg::mem_wr_t         wr2;
  logic                      res_ok;
  logic [idll_pkg::ID_W-1:0] res_nb;

  logic accept;
  logic out_load;

  idll_link_mem #(
    .NODES (NODES)
  ) u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_req  (mem_rd_req),
    .rd_data (mem_rd)
  );

  assign in_ready = (state == idll_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  // reads on accept: anchor for an insert, the node itself otherwise
  always_comb begin
    mem_rd_req.en     = accept;
    mem_rd_req.a_addr = (mode == idll_pkg::MODE_INSERT) ? anchor_id : node_id;
    mem_rd_req.b_addr = node_id;
  end

  // ids at or above NODES count as absent
  assign node_pres   = mem_rd.b_pres && (32'(req_node) < NODES);
  assign anchor_pres = mem_rd.a_pres && (32'(req_anchor) < NODES);

  // work out the result and both write pairs from the read data
  always_comb begin
    ok         = 1'b0;
    res_nb_now = '0;
    nb         = req_side ? mem_rd.a_right : mem_rd.a_left;
    wr1        = '0;
    wr2_now    = '0;
    case (req_mode)
      idll_pkg::MODE_INSERT: begin
        ok = (32'(req_node) < NODES) && !mem_rd.b_pres && anchor_pres;
        wr1.l_addr     = req_node;
        wr1.l_pres     = 1'b1;
        wr1.r_addr     = req_node;
        wr2_now.l_pres = 1'b1;
        if (req_side) begin
          // node goes between anchor and its right neighbour
          wr1.l_link     = req_anchor;
          wr1.r_link     = nb;
          wr2_now.l_addr = nb;
          wr2_now.l_link = req_node;
          wr2_now.r_addr = req_anchor;
          wr2_now.r_link = req_node;
        end else begin
          // node goes between left neighbour and anchor
          wr1.l_link     = nb;
          wr1.r_link     = req_anchor;
          wr2_now.l_addr = req_anchor;
          wr2_now.l_link = req_node;
          wr2_now.r_addr = nb;
          wr2_now.r_link = req_node;
        end
      end
      idll_pkg::MODE_REMOVE: begin
        ok = (req_node != '0) && node_pres;
        // node itself drops out with cleared links, then its neighbours join
        wr1.l_addr     = req_node;
        wr1.r_addr     = req_node;
        wr2_now.l_addr = mem_rd.a_right;
        wr2_now.l_pres = 1'b1;
        wr2_now.l_link = mem_rd.a_left;
        wr2_now.r_addr = mem_rd.a_left;
        wr2_now.r_link = mem_rd.a_right;
      end
      idll_pkg::MODE_QUERY: begin
        ok         = node_pres;
        res_nb_now = node_pres ? mem_rd.a_right : '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    wr1.en     = ok && (req_mode != idll_pkg::MODE_QUERY);
    wr2_now.en = wr1.en;
  end

  // control sequence
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    mem_wr     = '0;
    unique case (state)
      idll_pkg::S_CLEAR: begin
        // sentinel and node 1 present and linked to each other both ways, all other entries absent
        mem_wr.en     = 1'b1;
        mem_wr.l_addr = clr_cnt;
        mem_wr.l_pres = (clr_cnt == idll_pkg::ID_W'(0)) || (clr_cnt == idll_pkg::ID_W'(1));
        mem_wr.l_link = (clr_cnt == idll_pkg::ID_W'(0)) ? idll_pkg::ID_W'(1) : '0;
        mem_wr.r_addr = clr_cnt;
        mem_wr.r_link = (clr_cnt == idll_pkg::ID_W'(0)) ? idll_pkg::ID_W'(1) : '0;
        if (clr_cnt == CLR_LAST) begin
          state_next = idll_pkg::S_IDLE;
        end
      end
      idll_pkg::S_IDLE: begin
        if (accept) begin
          state_next = idll_pkg::S_RD;
        end
      end
      idll_pkg::S_RD: begin
        mem_wr     = wr1;
        state_next = idll_pkg::S_WR2;
      end
      idll_pkg::S_WR2: begin
        // hold until the output register is free, then commit once
        if (!out_valid || out_ready) begin
          mem_wr     = wr2;
          out_load   = 1'b1;
          state_next = idll_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = idll_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= idll_pkg::S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == idll_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + idll_pkg::ID_W'(1);
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode   <= mode;
      req_node   <= node_id;
      req_anchor <= anchor_id;
      req_side   <= side;
    end
  end

  // second write pair and result, held over the last step
  always_ff @(posedge clk) begin
    if (state == idll_pkg::S_RD) begin
      wr2    <= wr2_now;
      res_ok <= ok;
      res_nb <= res_nb_now;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      neighbour_id <= res_nb;
      status       <= !res_ok;
    end
  end

  // an accepted word always moves on to the read step
  a_accept_to_rd: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == idll_pkg::S_RD))
    else $error("accepted word did not reach the read step");

  // a result word only appears at the end of the second write step
  a_out_from_wr2: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == idll_pkg::S_WR2))
    else $error("result word loaded outside the last step");

  // an ignored request never reports a neighbour
  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (neighbour_id == '0))
    else $error("ignored request carries a neighbour id");

  // the two write pairs of one insert or remove touch different entries
  a_wr_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == idll_pkg::S_RD && wr1.en) |->
      (wr1.l_addr != wr2_now.l_addr) && (wr1.r_addr != wr2_now.r_addr))
    else $error("link writes of one request collide");

  // no memory write while idle
  a_idle_no_wr: assert property (@(posedge clk) disable iff (rst)
    (state == idll_pkg::S_IDLE) |-> !mem_wr.en)
    else $error("link memory written while idle");

endmodule

// ===== hdl/idll_link_mem.sv =====
// ----------------------------------------------------------------------------
// idll_link_mem
// left link memory (with present bit) and right link memory, registered read
// ----------------------------------------------------------------------------
module idll_link_mem #(
  parameter int NODES = 1024
) (
  input  logic                 clk,
  input  idll_pkg::mem_wr_t    wr,
  input  idll_pkg::mem_rdreq_t rd_req,
  output idll_pkg::mem_rd_t    rd_data
);

  // ids never exceed the port width, so deeper entries are unreachable
  localparam int DEPTH = (NODES < (1 << idll_pkg::ID_W)) ? NODES : (1 << idll_pkg::ID_W);
  localparam int AW    = $clog2(DEPTH);

  // left memory word: present bit over left link
  logic [idll_pkg::ID_W:0]   left_mem  [DEPTH];
  logic [idll_pkg::ID_W-1:0] right_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      left_mem[AW'(wr.l_addr)]  <= {wr.l_pres, wr.l_link};
      right_mem[AW'(wr.r_addr)] <= wr.r_link;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      {rd_data.a_pres, rd_data.a_left} <= left_mem[AW'(rd_req.a_addr)];
      {rd_data.b_pres, rd_data.b_left} <= left_mem[AW'(rd_req.b_addr)];
      rd_data.a_right                  <= right_mem[AW'(rd_req.a_addr)];
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for indexed_doubly_linked_list_core: a directed table of
// list edits and queries, then random insert / remove / walk traffic under
// three idling mixes and one long output stall; every result word is checked
// against a typed reply or a bench-side copy of the link arrays
// ----------------------------------------------------------------------------
module tb_top;

  localparam int         LIST_NODES   = 1024;
  localparam logic [1:0] MODE_NONE    = 2'd3;   // unused code, always ignored
  localparam logic       ST_DONE      = 1'b0;
  localparam logic       ST_IGNORED   = 1'b1;
  localparam bit         TYPED        = 1'b1;
  localparam bit         PREDICT      = 1'b0;
  localparam int         DIR_ROWS     = 25;
  localparam int         RAND_WORDS   = 850;
  localparam int         CYCLE_LIMIT  = 300000;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         HOLD_AT      = 700;
  localparam int         HOLD_CYCLES  = 300;

  typedef logic [idll_pkg::ID_W-1:0] id_t;

  typedef struct packed {
    id_t  neighbour;
    logic status;
  } reply_t;

  typedef struct packed {
    logic [1:0] op;
    id_t        node;
    id_t        anchor;
    logic       side;
    bit         typed;
    reply_t     reply;
  } req_row_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [1:0] mode      = idll_pkg::MODE_QUERY;
  id_t        node_id   = '0;
  id_t        anchor_id = '0;
  logic       side      = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  id_t        neighbour_id;
  logic       status;

  // bench copy of the list
  id_t    left_of  [LIST_NODES];
  id_t    right_of [LIST_NODES];
  bit     in_list  [LIST_NODES];
  reply_t pending_replies [$];
  id_t    walk_node       = '0;
  int     errors          = 0;
  int     replies_checked = 0;
  int     send_idle_pct   = 36;
  int     recv_idle_pct   = 70;
  int     hold_left       = 0;
  bit     hold_done       = 1'b0;

  // directed words: typed replies only where they are obvious
  req_row_t dir_rows [DIR_ROWS] = '{
    '{idll_pkg::MODE_QUERY,  10'd0,    10'd0, 1'b0, TYPED,   '{10'd1, ST_DONE}},
    '{idll_pkg::MODE_QUERY,  10'd1,    10'd0, 1'b0, TYPED,   '{10'd0, ST_DONE}},
    '{idll_pkg::MODE_QUERY,  10'd1023, 10'd0, 1'b0, TYPED,   '{10'd0, ST_IGNORED}},
    '{idll_pkg::MODE_INSERT, 10'd0,    10'd1, 1'b1, TYPED,   '{10'd0, ST_IGNORED}},
    '{idll_pkg::MODE_INSERT, 10'd1,    10'd0, 1'b1, TYPED,   '{10'd0, ST_IGNORED}},
    '{idll_pkg::MODE_INSERT, 10'd5,    10'd7, 1'b0, TYPED,   '{10'd0, ST_IGNORED}},
    '{idll_pkg::MODE_INSERT, 10'd1023, 10'd0, 1'b1, TYPED,   '{10'd0, ST_DONE}},
    '{idll_pkg::MODE_INSERT, 10'd2,    10'd0, 1'b0, TYPED,   '{10'd0, ST_DONE}},
    '{idll_pkg::MODE_QUERY,  10'd0,    10'd0, 1'b0, PREDICT, '{10'd0, ST_DONE}},
    '{idll_pkg::MODE_QUERY,  10'd1023, 10'd0, 1'b0, PREDICT, '{10'd0, ST_DONE}},
    '{idll_pkg::MODE_REMOVE, 10'd0,    10'd0, 1'b0, TYPED,   '{10'd0, ST_IGNORED}},
    '{idll_pkg::MODE_REMOVE, 10'd500,  10'd0, 1'b0, TYPED,   '{10'd0, ST_IGNORED}},
    '{idll_pkg::MODE_REMOVE, 10'd1,    10'd0, 1'b0, PREDICT, '{10'd0, ST_DONE}},
    '{idll_pkg::MODE_REMOVE, 10'd1,    10'd0, 1'b0, TYPED,   '{10'd0, ST_IGNORED}},
    '{idll_pkg::MODE_QUERY,  10'd1,    10'd0, 1'b0, TYPED,   '{10'd0, ST_IGNORED}},
    '{idll_pkg::MODE_REMOVE, 10'd1023, 10'd0, 1'b0, PREDICT, '{10'd0, ST_DONE}},
    '{idll_pkg::MODE_REMOVE, 10'd2,    10'd0, 1'b0, PREDICT, '{10'd0, ST_DONE}},
    '{idll_pkg::MODE_QUERY,  10'd0,    10'd0, 1'b0, TYPED,   '{10'd0, ST_DONE}},
    '{idll_pkg::MODE_INSERT, 10'd3,    10'd0, 1'b0, PREDICT, '{10'd0, ST_DONE}},
    '{idll_pkg::MODE_INSERT, 10'd1,    10'd3, 1'b0, PREDICT, '{10'd0, ST_DONE}},
    '{idll_pkg::MODE_INSERT, 10'd682,  10'd3, 1'b1, PREDICT, '{10'd0, ST_DONE}},
    '{idll_pkg::MODE_INSERT, 10'd341,  10'd1, 1'b1, PREDICT, '{10'd0, ST_DONE}},
    '{idll_pkg::MODE_QUERY,  10'd0,    10'd0, 1'b0, PREDICT, '{10'd0, ST_DONE}},
    '{MODE_NONE,   10'd0,    10'd0,    1'b0, TYPED,   '{10'd0, ST_IGNORED}},
    '{MODE_NONE,   10'd1023, 10'd1023, 1'b1, TYPED,   '{10'd0, ST_IGNORED}}
  };

  indexed_doubly_linked_list_core #(
    .NODES(LIST_NODES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .node_id      (node_id),
    .anchor_id    (anchor_id),
    .side         (side),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .neighbour_id (neighbour_id),
    .status       (status)
  );

  initial begin : clock_gen
    forever #5 clk = ~clk;
  end

  // sentinel and node 1 linked to each other, nothing else present
  function automatic void reset_list();
    for (int i = 0; i < LIST_NODES; i++) begin
      left_of[i]  = '0;
      right_of[i] = '0;
      in_list[i]  = 1'b0;
    end
    left_of[0]  = id_t'(1);
    right_of[0] = id_t'(1);
    in_list[0]  = 1'b1;
    in_list[1]  = 1'b1;
  endfunction

  function automatic bit listed(id_t id);
    return int'(id) < LIST_NODES && in_list[id];
  endfunction

  // applies one request word to the bench list and returns its reply
  function automatic reply_t apply_request(logic [1:0] op, id_t node, id_t anchor,
                                           logic to_right);
    reply_t r;
    id_t    nb;
    id_t    lnb;
    id_t    rnb;
    r.neighbour = '0;
    r.status    = ST_IGNORED;
    case (op)
      idll_pkg::MODE_INSERT: begin
        if (int'(node) < LIST_NODES && !in_list[node] && listed(anchor)) begin
          if (to_right) begin
            nb               = right_of[anchor];
            right_of[node]   = nb;
            left_of[node]    = anchor;
            right_of[anchor] = node;
            left_of[nb]      = node;
          end else begin
            nb              = left_of[anchor];
            left_of[node]   = nb;
            right_of[node]  = anchor;
            left_of[anchor] = node;
            right_of[nb]    = node;
          end
          in_list[node] = 1'b1;
          r.status      = ST_DONE;
        end
      end
      idll_pkg::MODE_REMOVE: begin
        // sentinel never leaves
        if (node != '0 && listed(node)) begin
          lnb            = left_of[node];
          rnb            = right_of[node];
          right_of[lnb]  = rnb;
          left_of[rnb]   = lnb;
          left_of[node]  = '0;
          right_of[node] = '0;
          in_list[node]  = 1'b0;
          r.status       = ST_DONE;
        end
      end
      idll_pkg::MODE_QUERY: begin
        if (listed(node)) begin
          r.neighbour = right_of[node];
          r.status    = ST_DONE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // mostly a small id pool so anchors and removes usually hit present nodes
  function automatic id_t pick_id();
    if ($urandom_range(0, 99) < 75) return id_t'($urandom_range(0, 47));
    return id_t'($urandom_range(0, LIST_NODES - 1));
  endfunction

  function automatic id_t pick_listed();
    id_t id;
    id = pick_id();
    for (int t = 0; t < 16 && !listed(id); t++) id = pick_id();
    return listed(id) ? id : '0;
  endfunction

  function automatic id_t pick_unlisted();
    id_t id;
    id = pick_id();
    for (int t = 0; t < 16 && listed(id); t++) id = pick_id();
    return id;
  endfunction

  // well-formed edits and list walks, with some broken requests mixed in
  function automatic req_row_t random_request();
    req_row_t rq;
    int       pick;
    pick      = $urandom_range(0, 99);
    rq.typed  = PREDICT;
    rq.reply  = '0;
    rq.node   = pick_id();
    rq.anchor = id_t'($urandom_range(0, LIST_NODES - 1));
    rq.side   = 1'($urandom_range(0, 1));
    if (pick < 35) begin
      rq.op     = idll_pkg::MODE_INSERT;
      rq.node   = pick_unlisted();
      rq.anchor = pick_listed();
    end else if (pick < 65) begin
      rq.op   = idll_pkg::MODE_REMOVE;
      rq.node = pick_listed();
    end else if (pick < 88) begin
      // next step of the walk, restarting at the sentinel at the end
      rq.op   = idll_pkg::MODE_QUERY;
      rq.node = walk_node;
    end else if (pick < 94) begin
      rq.op = idll_pkg::MODE_QUERY;
    end else if (pick < 97) begin
      rq.op = idll_pkg::MODE_INSERT;
    end else begin
      rq.op = MODE_NONE;
    end
    return rq;
  endfunction

  initial begin : stimulus
    req_row_t req;
    reply_t   model;
    reset_list();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIR_ROWS + RAND_WORDS; i++) begin
      if (i == DIR_ROWS + RAND_WORDS / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 36;
      end
      if (i == DIR_ROWS + 2 * RAND_WORDS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      req = (i < DIR_ROWS) ? dir_rows[i] : random_request();
      if ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
      end
      in_valid  <= 1'b1;
      mode      <= req.op;
      node_id   <= req.node;
      anchor_id <= req.anchor;
      side      <= req.side;
      do @(posedge clk); while (!in_ready);
      model = apply_request(req.op, req.node, req.anchor, req.side);
      pending_replies = {pending_replies, (req.typed ? req.reply : model)};
      if (req.op == idll_pkg::MODE_QUERY) walk_node = model.neighbour;
    end
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // result side: check the word taken at this edge, then pick the next ready
  always @(posedge clk) begin : reply_side
    reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: expected no word, actual neighbour_id %0d status %0d",
                 $time, neighbour_id, status);
      end else begin
        want = pending_replies.pop_front();
        if (neighbour_id !== want.neighbour) begin
          errors++;
          $display("%0t: neighbour_id expected %0d actual %0d",
                   $time, want.neighbour, neighbour_id);
        end
        if (status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        end
      end
      replies_checked++;
    end
    // one long stall so the core backs up into its input
    if (!hold_done && replies_checked >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== indexed_doubly_linked_list_core.f =====
hdl/idll_pkg.sv
hdl/idll_link_mem.sv
hdl/indexed_doubly_linked_list_core.sv
tb/sv/tb_top.sv
